// ===== sv/bba_pkg.sv =====
// shared constants, types and command/status bundles for the bitmap block allocator
// no dependencies; imported by bba_ctrl, bba_datapath and bitmap_block_allocator_core
package bba_pkg;

  localparam int MAP_BITS  = 4096;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;

  localparam int IDX_W  = $clog2(MAP_BITS);   // bit index into the map
  localparam int LIM_W  = IDX_W + 1;          // can hold MAP_BITS itself
  localparam int WA_W   = $clog2(MAP_WORDS);  // word address
  localparam int WCNT_W = WA_W + 1;           // can hold MAP_WORDS itself
  localparam int BIT_W  = $clog2(WORD_BITS);  // bit within a word

  localparam int BLK_W  = 32;
  localparam int SLIM_W = 13;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } bba_status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_BLOCK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LIMIT = 2'd2;

  typedef struct packed {
    logic load_req;      // capture the input beat
    logic prep;          // clamp limit, range checks, clear scan counters
    logic scan;          // issue next word read and check previous one
    logic alloc_commit;  // final range check and write-back of found bit
    logic free_read;     // read the word holding the block to free
    logic free_commit;   // test and clear the bit
    logic set_full;      // result: no free block
    logic set_range;     // result: out of range
    logic out_load;      // move result into the output register
  } bba_cmd_t;

  typedef struct packed {
    logic is_free_op;
    logic lim_zero;
    logic scan_hit;
    logic scan_miss;
    logic range_bad;
  } bba_stat_t;

endpackage

// ===== sv/bba_datapath.sv =====
// datapath of the bitmap block allocator: config registers, bitmap memory,
// word scan, range checks and result registers; depends on bba_pkg
module bba_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::BLK_W-1:0]     cfg_data,
  input  logic                          in_opcode,
  input  logic [bba_pkg::BLK_W-1:0]     in_block_number,
  input  bba_pkg::bba_cmd_t             cmd,
  output bba_pkg::bba_stat_t            stat,
  output logic [bba_pkg::BLK_W-1:0]     out_allocated_block,
  output logic [1:0]                    out_status
);
  import bba_pkg::*;

  logic [BLK_W-1:0]     data_start_r, last_block_r;
  logic [SLIM_W-1:0]    search_limit_r;
  logic                 op_r;
  logic [BLK_W-1:0]     blk_r;
  logic [LIM_W-1:0]     lim_r;
  logic [WCNT_W-1:0]    nwords_r, rd_cnt_r;
  logic                 chk_v_r;
  logic [WA_W-1:0]      chk_idx_r;
  logic [BLK_W-1:0]     diff_r;
  logic                 range_bad_r;
  logic [IDX_W-1:0]     found_idx_r;
  logic [WORD_BITS-1:0] new_word_r;
  logic [BLK_W-1:0]     res_blk_r, out_blk_r;
  bba_status_t          res_st_r, out_st_r;

  // bitmap memory, rows valid-tracked so reset reads as all free
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] row_vld_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;

  logic                 rd_en;
  logic [WA_W-1:0]      rd_addr;
  logic                 we;
  logic [WA_W-1:0]      wa;
  logic [WORD_BITS-1:0] wd;

  logic [WORD_BITS-1:0] word, lim_mask, cand, bit_mask;
  logic [BIT_W-1:0]     first_pos;
  logic                 issue;
  logic [LIM_W-1:0]     lim_c;
  logic [LIM_W-1:0]     lim_up;
  logic [BLK_W:0]       found_blk;
  logic                 alloc_ok;

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (v[b]) p = BIT_W'(b);
    end
    return p;
  endfunction

  assign word  = rd_vld_r ? rd_data_r : '0;
  assign issue = cmd.scan && (rd_cnt_r < nwords_r);

  always_comb begin
    if (32'(search_limit_r) > 32'(MAP_BITS)) lim_c = LIM_W'(MAP_BITS);
    else lim_c = LIM_W'(search_limit_r);
  end
  assign lim_up = lim_c + LIM_W'(WORD_BITS - 1);

  // bits past the limit in the last partial word count as used
  always_comb begin
    if ((WCNT_W'(chk_idx_r) == lim_r[LIM_W-1:BIT_W]) && (lim_r[BIT_W-1:0] != '0)) begin
      lim_mask = ~({WORD_BITS{1'b1}} << lim_r[BIT_W-1:0]);
    end else begin
      lim_mask = '1;
    end
  end
  assign cand      = ~word & lim_mask;
  assign first_pos = lowest_set(cand);
  assign bit_mask  = WORD_BITS'(1) << diff_r[BIT_W-1:0];

  assign found_blk = {1'b0, data_start_r} + (BLK_W+1)'(found_idx_r);
  assign alloc_ok  = (found_blk <= {1'b0, last_block_r}) && (found_blk != '0);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_cnt_r[WA_W-1:0];
    if (issue) begin
      rd_en = 1'b1;
    end else if (cmd.free_read) begin
      rd_en   = 1'b1;
      rd_addr = diff_r[IDX_W-1:BIT_W];
    end
  end

  always_comb begin
    we = 1'b0;
    wa = found_idx_r[IDX_W-1:BIT_W];
    wd = new_word_r;
    if (cmd.alloc_commit && alloc_ok) begin
      we = 1'b1;
    end else if (cmd.free_commit && word[diff_r[BIT_W-1:0]]) begin
      we = 1'b1;
      wa = diff_r[IDX_W-1:BIT_W];
      wd = word & ~bit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (we) row_vld_r[wa] <= 1'b1;
      if (rd_en) rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r   <= BLK_W'(1);
      last_block_r   <= BLK_W'(4096);
      search_limit_r <= SLIM_W'(4096);
      chk_v_r        <= 1'b0;
      rd_cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DATA_START:   data_start_r   <= cfg_data;
          CFG_LAST_BLOCK:   last_block_r   <= cfg_data;
          CFG_SEARCH_LIMIT: search_limit_r <= cfg_data[SLIM_W-1:0];
          default: ;
        endcase
      end
      if (cmd.prep) begin
        rd_cnt_r <= '0;
        chk_v_r  <= 1'b0;
      end else if (cmd.scan) begin
        chk_v_r <= issue;
        if (issue) rd_cnt_r <= rd_cnt_r + WCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= in_opcode;
      blk_r <= in_block_number;
    end
    if (cmd.prep) begin
      lim_r       <= lim_c;
      nwords_r    <= lim_up[LIM_W-1:BIT_W];
      diff_r      <= blk_r - data_start_r;
      range_bad_r <= (blk_r < data_start_r) || (blk_r > last_block_r) ||
                     ((blk_r - data_start_r) >= BLK_W'(MAP_BITS));
    end
    if (cmd.scan) chk_idx_r <= rd_cnt_r[WA_W-1:0];
    if (cmd.scan && chk_v_r && (cand != '0)) begin
      found_idx_r <= {chk_idx_r, first_pos};
      new_word_r  <= word | (WORD_BITS'(1) << first_pos);
    end
    if (cmd.alloc_commit) begin
      res_blk_r <= alloc_ok ? found_blk[BLK_W-1:0] : '0;
      res_st_r  <= alloc_ok ? ST_OK : ST_RANGE;
    end
    if (cmd.free_commit) begin
      res_blk_r <= '0;
      res_st_r  <= word[diff_r[BIT_W-1:0]] ? ST_OK : ST_FREE;
    end
    if (cmd.set_full) begin
      res_blk_r <= '0;
      res_st_r  <= ST_FULL;
    end
    if (cmd.set_range) begin
      res_blk_r <= '0;
      res_st_r  <= ST_RANGE;
    end
    if (cmd.out_load) begin
      out_blk_r <= res_blk_r;
      out_st_r  <= res_st_r;
    end
  end

  assign stat.is_free_op = (op_r == OP_FREE);
  assign stat.lim_zero   = (nwords_r == '0);
  assign stat.scan_hit   = chk_v_r && (cand != '0);
  assign stat.scan_miss  = chk_v_r && (cand == '0) &&
                           ((WCNT_W'(chk_idx_r) + WCNT_W'(1)) == nwords_r);
  assign stat.range_bad  = range_bad_r;

  assign out_allocated_block = out_blk_r;
  assign out_status          = out_st_r;

endmodule

// ===== sv/bba_ctrl.sv =====
// controller state machine of the bitmap block allocator
// sequences request capture, scan, commit and result hand-off; depends on bba_pkg
module bba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  bba_pkg::bba_stat_t stat,
  output bba_pkg::bba_cmd_t  cmd
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_ALLOC_CHK,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = stat.is_free_op ? S_FREE_RD : S_SCAN;
      end
      S_SCAN: begin
        if (stat.lim_zero || stat.scan_miss) begin
          cmd.set_full = 1'b1;
          state_nxt    = S_RESP;
        end else if (stat.scan_hit) begin
          // scan strobe captures the found index and the updated word
          cmd.scan  = 1'b1;
          state_nxt = S_ALLOC_CHK;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_ALLOC_CHK: begin
        cmd.alloc_commit = 1'b1;
        state_nxt        = S_RESP;
      end
      S_FREE_RD: begin
        if (stat.range_bad) begin
          cmd.set_range = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.free_read = 1'b1;
          state_nxt     = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        cmd.free_commit = 1'b1;
        state_nxt       = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/bitmap_block_allocator_core.sv =====
// top level of the first-fit bitmap block allocator
// sequence: free goes through prep, bitmap read and bit check to out_valid (out of range skips the
// read and check); allocate time grows with w, the index of the bitmap word holding the first free bit (up to 63)
// throughput: one request at a time; the single-port word scan sets allocation time
// reset: synchronous, bitmap reads as all free at once through per-word valid bits
// depends on bba_pkg, bba_ctrl and bba_datapath
module bitmap_block_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write channel, always ready
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::BLK_W-1:0]     cfg_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [bba_pkg::BLK_W-1:0]     in_block_number,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bba_pkg::BLK_W-1:0]     out_allocated_block,
  output logic [1:0]                    out_status
);
  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t stat;

  // config beats are taken at any time; writes belong between requests
  assign cfg_ready = 1'b1;

  // controller: one request in flight, result parked in the output register
  // so the next request can be taken while the last beat waits
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: bitmap memory scanned one word per cycle, read and check overlapped
  bba_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_opcode           (in_opcode),
    .in_block_number     (in_block_number),
    .cmd                 (cmd),
    .stat                (stat),
    .out_allocated_block (out_allocated_block),
    .out_status          (out_status)
  );

endmodule

// ===== bench/tb_bitmap_block_allocator_core.sv =====
// self-checking bench for bitmap_block_allocator_core: directed edge cases, then random
// alloc/free traffic under three idling mixes, checked against a bitmap mirror
// depends on bba_pkg and the allocator rtl
module tb_bitmap_block_allocator_core;
  import bba_pkg::*;

  localparam int          HALF_PERIOD    = 5;
  localparam int          SETTLE_CYCLES  = 4;   // idle gap before register writes
  localparam int          TAIL_CYCLES    = 80;  // idle tail before the check for beats that never arrived
  localparam int unsigned RUN_LIMIT      = 8_000_000;
  localparam int          ITEMS_PER_MIX  = 150;
  // index 3 has no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // one expected result beat
  typedef struct {
    logic [BLK_W-1:0] block;
    bba_status_t      status;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BLK_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_opcode;
  logic [BLK_W-1:0]     in_block_number;
  logic                 out_valid;
  logic                 out_ready;
  logic [BLK_W-1:0]     out_allocated_block;
  logic [1:0]           out_status;

  // mirror of the block's registers and bitmap
  logic [BLK_W-1:0]  base_block;
  logic [BLK_W-1:0]  last_blk;
  logic [SLIM_W-1:0] search_lim;
  bit                map_mirror [MAP_BITS];   // bit type, so starts all free
  int                used_idx [$];            // bitmap indexes currently marked used

  reply_t replies_due [$];
  int     send_gap_pct;
  int     recv_stall_pct;
  int     mismatches;
  int     results_seen;
  int     requests_sent;
  int     outcome_tally [2][4];

  bitmap_block_allocator_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_block_number     (in_block_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_allocated_block (out_allocated_block),
    .out_status          (out_status)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // first-fit allocate or checked free against the mirror, queues the expected beat
  task automatic predict_request(input logic op, input logic [BLK_W-1:0] blk);
    reply_t           r;
    int               lim;
    int               hit;
    int               i;
    int               k;
    bit               found;
    logic [BLK_W:0]   cand;
    logic [BLK_W-1:0] offs;
    r.block  = '0;
    r.status = ST_OK;
    if (op == OP_ALLOC) begin
      // a limit above the map size only searches the map
      lim   = (int'(search_lim) > MAP_BITS) ? MAP_BITS : int'(search_lim);
      found = 1'b0;
      hit   = 0;
      for (i = 0; i < lim && !found; i++) begin
        if (!map_mirror[i]) begin
          found = 1'b1;
          hit   = i;
        end
      end
      if (!found) begin
        r.status = ST_FULL;
      end else begin
        // 33-bit sum so a carry out of 32 bits counts as beyond last_block
        cand = base_block + hit;
        if (cand > {1'b0, last_blk} || cand == '0) begin
          r.status = ST_RANGE;
        end else begin
          map_mirror[hit] = 1'b1;
          used_idx.push_back(hit);
          r.block = cand[BLK_W-1:0];
        end
      end
    end else begin
      offs = blk - base_block;
      if (blk < base_block || blk > last_blk || offs >= MAP_BITS) begin
        r.status = ST_RANGE;
      end else if (!map_mirror[offs]) begin
        r.status = ST_FREE;
      end else begin
        map_mirror[offs] = 1'b0;
        for (k = used_idx.size() - 1; k >= 0; k--) begin
          if (used_idx[k] == int'(offs)) used_idx.delete(k);
        end
      end
    end
    outcome_tally[op][r.status]++;
    replies_due.push_back(r);
  endtask

  // one request beat; called and returns at a falling edge, valid left high
  task automatic send_request(input logic op, input logic [BLK_W-1:0] blk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_block_number <= blk;
    do @(posedge clk); while (!in_ready);
    predict_request(op, blk);
    requests_sent++;
    @(negedge clk);
  endtask

  // drop valid and wait until every expected beat has come back
  task automatic settle_outstanding();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BLK_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DATA_START:   base_block = value;
      CFG_LAST_BLOCK:   last_blk   = value;
      CFG_SEARCH_LIMIT: search_lim = value[SLIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // result checker, oldest expectation first
  always @(posedge clk) begin : check_results
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat: block %h status %0d",
                                out_allocated_block, out_status));
      end else begin
        want = replies_due.pop_front();
        results_seen++;
        if (out_allocated_block !== want.block)
          flag_mismatch($sformatf("allocated_block got %h want %h",
                                  out_allocated_block, want.block));
        if (out_status !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d (block %h)",
                                  out_status, want.status, want.block));
      end
    end
  end

  // default registers: lowest fit, hole reuse, double free, free outside the range
  task automatic test_first_fit_and_free();
    send_request(OP_ALLOC, 32'hFFFF_FFFF);  // block number ignored on allocate
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_ALLOC, $urandom);
    send_request(OP_FREE, 32'd2);
    send_request(OP_ALLOC, $urandom);        // refills the hole at block 2
    send_request(OP_FREE, 32'd2);
    send_request(OP_FREE, 32'd2);            // already free
    send_request(OP_FREE, 32'd0);            // below data_start
    send_request(OP_FREE, 32'd4097);         // above last_block
    send_request(OP_FREE, 32'hFFFF_FFFF);
    send_request(OP_FREE, 32'd1);
    send_request(OP_FREE, 32'd3);
    settle_outstanding();
  endtask

  // zero limit, one-bit limit until full, limit above the map size
  task automatic test_search_limit_edges();
    write_reg(CFG_SEARCH_LIMIT, 32'd0);
    send_request(OP_ALLOC, $urandom);
    settle_outstanding();
    write_reg(CFG_SEARCH_LIMIT, 32'd1);
    send_request(OP_ALLOC, $urandom);
    send_request(OP_ALLOC, $urandom);        // only bit is used, so full
    settle_outstanding();
    write_reg(CFG_SEARCH_LIMIT, 32'd8191);
    send_request(OP_ALLOC, $urandom);
    send_request(OP_FREE, 32'd1);
    send_request(OP_FREE, 32'd2);
    settle_outstanding();
  endtask

  // found block past last_block, block zero, 32-bit carry, index past the map,
  // and a write to the unused register index
  task automatic test_range_edges();
    write_reg(CFG_LAST_BLOCK, 32'd1);
    send_request(OP_ALLOC, $urandom);
    send_request(OP_ALLOC, $urandom);
    send_request(OP_FREE, 32'd1);
    settle_outstanding();
    write_reg(CFG_DATA_START, 32'd0);
    write_reg(CFG_LAST_BLOCK, 32'd4096);
    send_request(OP_ALLOC, $urandom);
    send_request(OP_FREE, 32'd0);
    settle_outstanding();
    write_reg(CFG_DATA_START, 32'hFFFF_FFFF);
    write_reg(CFG_LAST_BLOCK, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, $urandom);
    send_request(OP_ALLOC, $urandom);        // sum carries out of 32 bits
    send_request(OP_FREE, 32'hFFFF_FFFF);
    settle_outstanding();
    write_reg(CFG_DATA_START, 32'd1);
    write_reg(CFG_UNUSED_IDX, $urandom);
    send_request(OP_FREE, 32'd4097);         // bit index equals map size
    send_request(OP_FREE, 32'd4096);
    settle_outstanding();
  endtask

  // random settings per segment, mostly well-formed alloc/free pairs plus noise
  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int items);
    int               sent;
    int               seg_len;
    int               n;
    int               kind;
    int               alloc_pct;
    int               pick;
    logic [BLK_W-1:0] ds;
    logic [BLK_W-1:0] lb;
    logic [BLK_W-1:0] sl;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      settle_outstanding();
      kind = $urandom_range(5);
      case (kind)
        0: begin  // plain window, modest limit
          ds = $urandom_range(64, 1);
          lb = ds + 4095;
          sl = $urandom_range(160, 1);
        end
        1: begin  // anything goes, high data bits of the limit must be dropped
          ds = $urandom;
          lb = $urandom;
          sl = $urandom;
        end
        2: begin  // top of the block number space
          ds = 32'hFFFF_FFFF - $urandom_range(100);
          lb = 32'hFFFF_FFFF;
          sl = $urandom_range(300, 1);
        end
        3: begin  // tight last_block, full or oversized limit
          ds = $urandom_range(3);
          lb = ds + $urandom_range(80);
          sl = $urandom_range(1) ? 32'd4096 : 32'd8191;
        end
        4: begin
          ds = $urandom_range(2000, 1);
          lb = ds + $urandom_range(200, 20);
          sl = $urandom_range(120, 20);
        end
        default: begin  // tiny limit, fills quickly
          ds = 32'd1;
          lb = 32'd4096;
          sl = $urandom_range(8, 1);
        end
      endcase
      write_reg(CFG_DATA_START, ds);
      write_reg(CFG_LAST_BLOCK, lb);
      write_reg(CFG_SEARCH_LIMIT, sl);
      if ($urandom_range(3) == 0) write_reg(CFG_UNUSED_IDX, $urandom);
      alloc_pct = $urandom_range(65, 35);
      seg_len   = $urandom_range(40, 20);
      for (n = 0; n < seg_len && sent < items; n++) begin
        // now and then hold off until the pipe has emptied
        if ($urandom_range(99) < 3) settle_outstanding();
        pick = $urandom_range(99);
        if (pick < alloc_pct)
          send_request(OP_ALLOC, $urandom);
        else if (pick < alloc_pct + 30 && used_idx.size() != 0)
          send_request(OP_FREE, base_block + used_idx[$urandom_range(used_idx.size() - 1)]);
        else if (pick < 92)
          send_request(OP_FREE, base_block - 1 + $urandom_range(4100));
        else
          send_request(1'($urandom_range(1)), $urandom);
        sent++;
      end
    end
    settle_outstanding();
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_opcode       = OP_ALLOC;
    in_block_number = '0;
    out_ready       = 1'b0;
    base_block      = 32'd1;
    last_blk        = 32'd4096;
    search_lim      = 13'd4096;
    send_gap_pct    = 19;
    recv_stall_pct  = 55;
    mismatches      = 0;
    results_seen    = 0;
    requests_sent   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_first_fit_and_free();
    test_search_limit_edges();
    test_range_edges();
    // sender gaps light and receiver stalls heavy, then swapped, then flat out
    test_random_traffic(19, 55, ITEMS_PER_MIX);
    test_random_traffic(55, 19, ITEMS_PER_MIX);
    test_random_traffic(0, 0, ITEMS_PER_MIX);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (replies_due.size() != 0)
      flag_mismatch($sformatf("%0d expected beats never arrived", replies_due.size()));

    $display("covered %0d requests, %0d results: allocs ok %0d, no free block %0d, range %0d",
             requests_sent, results_seen, outcome_tally[OP_ALLOC][ST_OK],
             outcome_tally[OP_ALLOC][ST_FULL], outcome_tally[OP_ALLOC][ST_RANGE]);
    $display("frees ok %0d, range %0d, already free %0d; %0d mismatches",
             outcome_tally[OP_FREE][ST_OK], outcome_tally[OP_FREE][ST_RANGE],
             outcome_tally[OP_FREE][ST_FREE], mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/bba_pkg.sv
sv/bba_datapath.sv
sv/bba_ctrl.sv
sv/bitmap_block_allocator_core.sv
bench/tb_bitmap_block_allocator_core.sv
